[sv/json_path_tokenizer_defines.svh]
// ----------------------------------------------------------------------------
// json_path_tokenizer_defines
// Assertion macros shared by the checker of the path tokenizer.
// ----------------------------------------------------------------------------
`ifndef JSON_PATH_TOKENIZER_DEFINES_SVH
`define JSON_PATH_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define JPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define JPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/jpt_pkg.sv]
// ----------------------------------------------------------------------------
// jpt_pkg
// Types and constants of the JSON-path tokenizer.
// ----------------------------------------------------------------------------
package jpt_pkg;

	// Kind of one emitted part
	typedef enum logic [2:0] {
		PK_ROOT   = 3'd0,
		PK_ALL    = 3'd1,
		PK_INDEX  = 3'd2,
		PK_KEY    = 3'd3,
		PK_END    = 3'd4,
		PK_ERROR  = 3'd5
	} part_kind_t;

	// Error codes
	typedef enum logic [2:0] {
		ERR_EMPTY_KEY    = 3'd0,
		ERR_NO_BRACKET_Q = 3'd1,
		ERR_UNTERM_QUOTE = 3'd2,
		ERR_NO_CLOSE     = 3'd3,
		ERR_NOT_INT      = 3'd4,
		ERR_RANGE        = 3'd5,
		ERR_UNEXPECTED   = 3'd6,
		ERR_TOO_LONG     = 3'd7
	} err_code_t;

	// Parser mode, one-hot
	typedef enum logic [7:0] {
		MODE_START  = 8'b0000_0001,
		MODE_TOP    = 8'b0000_0010,
		MODE_KEY    = 8'b0000_0100,
		MODE_BROPEN = 8'b0000_1000,
		MODE_BRBODY = 8'b0001_0000,
		MODE_BRBAD  = 8'b0010_0000,
		MODE_QUOTE  = 8'b0100_0000,
		MODE_AFTERQ = 8'b1000_0000
	} mode_t;

	// Input item kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Characters of the path syntax
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	// Results written into the queue by one request
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

endpackage

[sv/jpt_if.sv]
// ----------------------------------------------------------------------------
// jpt_if
// Valid/ready channels of the tokenizer: characters in, parts out.
// ----------------------------------------------------------------------------
interface jpt_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] ch;

	modport source (output valid, output kind, output ch, input ready);
	modport sink (input valid, input kind, input ch, output ready);
endinterface

interface jpt_out_if #(
	parameter int START_W = 10,
	parameter int LEN_W   = 11,
	parameter int INDEX_W = 32
);
	logic               valid;
	logic               ready;
	logic [2:0]         part_kind;
	logic [START_W-1:0] key_start;
	logic [LEN_W-1:0]   key_len;
	logic [INDEX_W-1:0] index_value;
	logic [2:0]         error_code;
	logic               last;

	modport source (output valid, output part_kind, output key_start, output key_len,
		output index_value, output error_code, output last, input ready);
	modport sink (input valid, input part_kind, input key_start, input key_len,
		input index_value, input error_code, input last, output ready);
endinterface

[sv/jpt_core.sv]
// ----------------------------------------------------------------------------
// jpt_core
// Parser state and per-character update; forms up to two results per request.
// ----------------------------------------------------------------------------
module jpt_core #(
	parameter int MAX_EXPR_LEN = 1024,
	parameter int INDEX_BITS   = 32,
	localparam int POS_W       = $clog2(MAX_EXPR_LEN + 1),
	localparam int START_W     = $clog2(MAX_EXPR_LEN),
	localparam int RES_W       = 3 + START_W + POS_W + INDEX_BITS + 3 + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               kind,
	input  logic [7:0]         ch,
	output jpt_pkg::push_t     push,
	output logic [RES_W-1:0]   res0,
	output logic [RES_W-1:0]   res1
);

	localparam int MUL_W = INDEX_BITS + 5;

	typedef struct packed {
		jpt_pkg::part_kind_t kind;
		logic [START_W-1:0]  start;
		logic [POS_W-1:0]    len;
		logic [INDEX_BITS-1:0] idx;
		jpt_pkg::err_code_t  err;
		logic                last;
	} res_t;

	function automatic res_t mk_part(jpt_pkg::part_kind_t k);
		res_t r;
		r      = '0;
		r.kind = k;
		r.last = (k == jpt_pkg::PK_END);
		return r;
	endfunction

	function automatic res_t mk_err(jpt_pkg::err_code_t e);
		res_t r;
		r      = '0;
		r.kind = jpt_pkg::PK_ERROR;
		r.err  = e;
		return r;
	endfunction

	// State registers
	jpt_pkg::mode_t        mode_q, mode_d;
	logic [POS_W-1:0]      pos_q, pos_d;
	logic [POS_W-1:0]      tok_q, tok_d;
	logic [INDEX_BITS:0]   acc_q, acc_d;
	logic                  digit_q, digit_d;
	logic                  minus_q, minus_d;
	logic                  star_q, star_d;
	logic                  err_q, err_d;

	res_t                  r0, r1;
	logic                  r0_v, r1_v;

	// Key between token start and current position
	logic [POS_W-1:0]      key_len;
	logic                  key_empty;
	res_t                  key_res;

	// Decimal digit accumulation
	logic                  is_digit;
	logic [3:0]            dval;
	logic [INDEX_BITS:0]   acc_base;
	logic [MUL_W-1:0]      acc_wide;
	logic [MUL_W-1:0]      acc_mul;
	logic                  acc_ovf;
	logic [INDEX_BITS:0]   acc_next;
	logic                  first_body;
	logic                  star_base;
	logic                  pos_full;

	assign key_len   = pos_q - tok_q;
	assign key_empty = (key_len == '0);

	always_comb begin
		key_res = mk_err(jpt_pkg::ERR_EMPTY_KEY);
		if (!key_empty) begin
			key_res       = mk_part(jpt_pkg::PK_KEY);
			key_res.start = tok_q[START_W-1:0];
			key_res.len   = key_len;
		end
	end

	assign is_digit   = (ch >= jpt_pkg::CH_ZERO) && (ch <= jpt_pkg::CH_NINE);
	assign dval       = 4'(ch - jpt_pkg::CH_ZERO);
	assign first_body = (mode_q == jpt_pkg::MODE_BROPEN);
	assign acc_base   = first_body ? '0 : acc_q;
	assign star_base  = first_body ? 1'b0 : star_q;
	assign acc_wide   = {4'b0000, acc_base};
	assign acc_mul    = (acc_wide << 3) + (acc_wide << 1) + MUL_W'(dval);
	assign acc_ovf    = acc_base[INDEX_BITS] | (|acc_mul[MUL_W-1:INDEX_BITS]);
	assign acc_next   = acc_ovf ? {1'b1, {INDEX_BITS{1'b0}}} : acc_mul[INDEX_BITS:0];
	assign pos_full   = (pos_q >= POS_W'(MAX_EXPR_LEN));

	// Next state and results of one request
	always_comb begin
		mode_d  = mode_q;
		pos_d   = pos_q;
		tok_d   = tok_q;
		acc_d   = acc_q;
		digit_d = digit_q;
		minus_d = minus_q;
		star_d  = star_q;
		err_d   = err_q;
		r0      = '0;
		r1      = mk_part(jpt_pkg::PK_END);
		r0_v    = 1'b0;
		r1_v    = 1'b0;

		if (kind == jpt_pkg::KIND_END) begin
			// Close the expression: flush a pending key or error, then end
			r1_v = 1'b1;
			if (!err_q) begin
				unique case (mode_q)
					jpt_pkg::MODE_KEY: begin
						r0   = key_res;
						r0_v = 1'b1;
					end
					jpt_pkg::MODE_BROPEN, jpt_pkg::MODE_BRBODY, jpt_pkg::MODE_BRBAD: begin
						r0   = mk_err(jpt_pkg::ERR_NO_CLOSE);
						r0_v = 1'b1;
					end
					jpt_pkg::MODE_QUOTE: begin
						r0   = mk_err(jpt_pkg::ERR_UNTERM_QUOTE);
						r0_v = 1'b1;
					end
					jpt_pkg::MODE_AFTERQ: begin
						r0   = mk_err(jpt_pkg::ERR_NO_BRACKET_Q);
						r0_v = 1'b1;
					end
					default: ;
				endcase
			end
			mode_d  = jpt_pkg::MODE_START;
			pos_d   = '0;
			tok_d   = '0;
			acc_d   = '0;
			digit_d = 1'b0;
			minus_d = 1'b0;
			star_d  = 1'b0;
			err_d   = 1'b0;
		end else if (!err_q) begin
			if (pos_full) begin
				r0    = mk_err(jpt_pkg::ERR_TOO_LONG);
				r0_v  = 1'b1;
				err_d = 1'b1;
			end else begin
				pos_d = pos_q + 1'b1;
				unique case (mode_q)
					jpt_pkg::MODE_START: begin
						if (ch == jpt_pkg::CH_DOLLAR) begin
							r0     = mk_part(jpt_pkg::PK_ROOT);
							r0_v   = 1'b1;
							mode_d = jpt_pkg::MODE_TOP;
						end else if (ch == jpt_pkg::CH_LBRACK) begin
							mode_d = jpt_pkg::MODE_BROPEN;
						end else begin
							tok_d  = pos_q;
							mode_d = jpt_pkg::MODE_KEY;
							if (ch == jpt_pkg::CH_DOT) begin
								r0    = mk_err(jpt_pkg::ERR_EMPTY_KEY);
								r0_v  = 1'b1;
								err_d = 1'b1;
							end
						end
					end
					jpt_pkg::MODE_TOP: begin
						if (ch == jpt_pkg::CH_DOT) begin
							tok_d  = pos_q + 1'b1;
							mode_d = jpt_pkg::MODE_KEY;
						end else if (ch == jpt_pkg::CH_LBRACK) begin
							mode_d = jpt_pkg::MODE_BROPEN;
						end else begin
							r0    = mk_err(jpt_pkg::ERR_UNEXPECTED);
							r0_v  = 1'b1;
							err_d = 1'b1;
						end
					end
					jpt_pkg::MODE_KEY: begin
						// A separator ends the key and, if the key is not empty, opens the next token
						if (ch == jpt_pkg::CH_DOT || ch == jpt_pkg::CH_LBRACK) begin
							r0    = key_res;
							r0_v  = 1'b1;
							err_d = key_empty;
							if (!key_empty) begin
								if (ch == jpt_pkg::CH_DOT) begin
									tok_d  = pos_q + 1'b1;
									mode_d = jpt_pkg::MODE_KEY;
								end else begin
									mode_d = jpt_pkg::MODE_BROPEN;
								end
							end
						end
					end
					jpt_pkg::MODE_BROPEN, jpt_pkg::MODE_BRBODY: begin
						if (first_body) begin
							acc_d   = '0;
							digit_d = 1'b0;
							minus_d = 1'b0;
							star_d  = 1'b0;
						end
						if (first_body && ch == jpt_pkg::CH_QUOTE) begin
							tok_d  = pos_q + 1'b1;
							mode_d = jpt_pkg::MODE_QUOTE;
						end else if (ch == jpt_pkg::CH_RBRACK) begin
							// Close the bracket: star, index or error
							mode_d = jpt_pkg::MODE_TOP;
							r0_v   = 1'b1;
							if (star_base) begin
								r0 = mk_part(jpt_pkg::PK_ALL);
							end else if (first_body || !digit_q) begin
								r0    = mk_err(jpt_pkg::ERR_NOT_INT);
								err_d = 1'b1;
							end else if (acc_q[INDEX_BITS] || (minus_q && acc_q != '0)) begin
								r0    = mk_err(jpt_pkg::ERR_RANGE);
								err_d = 1'b1;
							end else begin
								r0     = mk_part(jpt_pkg::PK_INDEX);
								r0.idx = acc_q[INDEX_BITS-1:0];
							end
						end else begin
							// Body character: sign, star or digit
							mode_d = jpt_pkg::MODE_BRBODY;
							if (star_base) begin
								mode_d = jpt_pkg::MODE_BRBAD;
							end else if (is_digit) begin
								acc_d   = acc_next;
								digit_d = 1'b1;
							end else if (first_body && ch == jpt_pkg::CH_STAR) begin
								star_d = 1'b1;
							end else if (first_body &&
								(ch == jpt_pkg::CH_MINUS || ch == jpt_pkg::CH_PLUS)) begin
								minus_d = (ch == jpt_pkg::CH_MINUS);
							end else begin
								mode_d = jpt_pkg::MODE_BRBAD;
							end
						end
					end
					jpt_pkg::MODE_BRBAD: begin
						if (ch == jpt_pkg::CH_RBRACK) begin
							r0    = mk_err(jpt_pkg::ERR_NOT_INT);
							r0_v  = 1'b1;
							err_d = 1'b1;
						end
					end
					jpt_pkg::MODE_QUOTE: begin
						if (ch == jpt_pkg::CH_QUOTE) begin
							r0     = key_res;
							r0_v   = 1'b1;
							err_d  = key_empty;
							mode_d = jpt_pkg::MODE_AFTERQ;
						end
					end
					jpt_pkg::MODE_AFTERQ: begin
						if (ch == jpt_pkg::CH_RBRACK) begin
							mode_d = jpt_pkg::MODE_TOP;
						end else begin
							r0    = mk_err(jpt_pkg::ERR_NO_BRACKET_Q);
							r0_v  = 1'b1;
							err_d = 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Advance state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= jpt_pkg::MODE_START;
			pos_q   <= '0;
			tok_q   <= '0;
			acc_q   <= '0;
			digit_q <= 1'b0;
			minus_q <= 1'b0;
			star_q  <= 1'b0;
			err_q   <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			tok_q   <= tok_d;
			acc_q   <= acc_d;
			digit_q <= digit_d;
			minus_q <= minus_d;
			star_q  <= star_d;
			err_q   <= err_d;
		end
	end

	assign push.first  = accept & r0_v;
	assign push.second = accept & r1_v;
	assign res0        = r0;
	assign res1        = r1;

endmodule

[sv/jpt_res_fifo.sv]
// ----------------------------------------------------------------------------
// jpt_res_fifo
// Four-entry result queue; takes up to two a cycle, gives one when out_ready.
// ----------------------------------------------------------------------------
module jpt_res_fifo #(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  jpt_pkg::push_t   push,
	input  logic [WIDTH-1:0] data0,
	input  logic [WIDTH-1:0] data1,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0]               mem_q [jpt_pkg::FIFO_DEPTH];
	logic [jpt_pkg::FIFO_PTR_W-1:0] wr_q, rd_q, wr_second;
	logic [jpt_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic [1:0]                     n_push;
	logic                           pop;

	assign n_push    = {1'b0, push.first} + {1'b0, push.second};
	assign wr_second = push.first ? wr_q + 1'b1 : wr_q;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid & out_ready;
	assign out_data  = mem_q[rd_q];
	assign room      = (cnt_q <= jpt_pkg::FIFO_CNT_W'(jpt_pkg::FIFO_DEPTH - 2));

	// Write results in order
	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[wr_q] <= data0;
		end
		if (push.second) begin
			mem_q[wr_second] <= data1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + jpt_pkg::FIFO_PTR_W'(n_push);
			rd_q  <= rd_q + jpt_pkg::FIFO_PTR_W'(pop);
			cnt_q <= cnt_q + jpt_pkg::FIFO_CNT_W'(n_push) - jpt_pkg::FIFO_CNT_W'(pop);
		end
	end

endmodule

[sv/json_path_tokenizer.sv]
// ----------------------------------------------------------------------------
// json_path_tokenizer
// Splits a JSON-path expression, one character per request, into parts.
// ----------------------------------------------------------------------------
// Takes one character (or the end mark) per cycle on chars while chars is
// ready and returns root, key, index, array-all, error and end parts on
// parts. The parser updates its state in the same cycle a character is
// taken; its results go into a four-entry queue that drains one part per
// cycle while parts is ready. chars is ready while the queue has at least
// two free entries, so an expression runs at one character per cycle as
// long as parts is taken; an end request may add two parts (pending key
// or error, then end). Results reach parts through the queue registers.
// Key offsets are counted from the first character of the expression.
module json_path_tokenizer #(
	parameter int MAX_EXPR_LEN = 1024,
	parameter int INDEX_BITS   = 32
) (
	input logic       clk,
	input logic       arst_n,
	jpt_in_if.sink    chars,
	jpt_out_if.source parts
);

	localparam int POS_W   = $clog2(MAX_EXPR_LEN + 1);
	localparam int START_W = $clog2(MAX_EXPR_LEN);
	localparam int RES_W   = 3 + START_W + POS_W + INDEX_BITS + 3 + 1;

	// Field offsets in a packed result
	localparam int OFS_ERR   = 1;
	localparam int OFS_IDX   = OFS_ERR + 3;
	localparam int OFS_LEN   = OFS_IDX + INDEX_BITS;
	localparam int OFS_START = OFS_LEN + POS_W;
	localparam int OFS_KIND  = OFS_START + START_W;

	logic             accept;
	logic             room;
	jpt_pkg::push_t   push;
	logic [RES_W-1:0] res0, res1, head;

	// Take a request while the queue can hold two results
	assign chars.ready = room;
	assign accept      = chars.valid & room;

	jpt_core #(
		.MAX_EXPR_LEN (MAX_EXPR_LEN),
		.INDEX_BITS   (INDEX_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.kind   (chars.kind),
		.ch     (chars.ch),
		.push   (push),
		.res0   (res0),
		.res1   (res1)
	);

	jpt_res_fifo #(
		.WIDTH (RES_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data0     (res0),
		.data1     (res1),
		.room      (room),
		.out_valid (parts.valid),
		.out_ready (parts.ready),
		.out_data  (head)
	);

	// Unpack the head of the queue
	assign parts.last        = head[0];
	assign parts.error_code  = head[OFS_IDX-1:OFS_ERR];
	assign parts.index_value = head[OFS_LEN-1:OFS_IDX];
	assign parts.key_len     = head[OFS_START-1:OFS_LEN];
	assign parts.key_start   = head[OFS_KIND-1:OFS_START];
	assign parts.part_kind   = head[RES_W-1:OFS_KIND];

endmodule

[sv/jpt_checker.sv]
// ----------------------------------------------------------------------------
// jpt_checker
// Port-level checks of the path tokenizer, bound to its top level.
// ----------------------------------------------------------------------------
`include "json_path_tokenizer_defines.svh"

module jpt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] part_kind,
	input logic       last,
	input logic       key_nonzero,
	input logic       err_nonzero
);

	// A shown part stays until taken
	`JPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "part dropped while stalled")

	// Only the end part is marked last
	`JPT_ASSERT_NOW(a_last_end, out_valid, last == (part_kind == jpt_pkg::PK_END), "last mismatch")

	// A key part never has zero length
	`JPT_ASSERT_NOW(a_key_len, out_valid && part_kind == jpt_pkg::PK_KEY, key_nonzero, "empty key part")

	// Error code is zero outside error parts
	`JPT_ASSERT_NOW(a_err_clean, out_valid && part_kind != jpt_pkg::PK_ERROR, !err_nonzero, "stray error code")

endmodule

bind json_path_tokenizer jpt_checker u_jpt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (parts.valid),
	.out_ready   (parts.ready),
	.part_kind   (parts.part_kind),
	.last        (parts.last),
	.key_nonzero (|parts.key_len),
	.err_nonzero (|parts.error_code)
);
